// ----- src/button_debounce_press_classifier_core_defines.svh -----
// Assertion helpers for the button debounce press classifier.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BDPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdpc assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define BDPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdpc assertion failed");

`endif

// ----- src/bdpc_pkg.sv -----
package bdpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 3;

  localparam logic [TimeW-1:0] LongPressRst = TimeW'(1000);
  localparam logic [TimeW-1:0] DebounceRst  = TimeW'(50);

  typedef enum logic [0:0] {
    REG_LONG_PRESS = 1'b0,
    REG_DEBOUNCE   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] long_press_ms;
    logic [TimeW-1:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             raw_pressed;
    logic             clear_short;
    logic             clear_long;
  } poll_t;

  typedef struct packed {
    logic             pressed;
    logic             short_event;
    logic             long_event;
    logic [TimeW-1:0] hold_duration;
  } result_t;

endpackage

// ----- src/bdpc_in_if.sv -----
interface bdpc_in_if;
  import bdpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_ms;
  logic             raw_pressed;
  logic             clear_short;
  logic             clear_long;

  modport source (output valid, now_ms, raw_pressed, clear_short, clear_long, input ready);
  modport sink   (input valid, now_ms, raw_pressed, clear_short, clear_long, output ready);
endinterface

// ----- src/bdpc_out_if.sv -----
interface bdpc_out_if;
  import bdpc_pkg::*;

  logic             valid;
  logic             ready;
  logic             pressed;
  logic             short_event;
  logic             long_event;
  logic [TimeW-1:0] hold_duration;

  modport source (output valid, pressed, short_event, long_event, hold_duration, input ready);
  modport sink   (input valid, pressed, short_event, long_event, hold_duration, output ready);
endinterface

// ----- src/bdpc_cfg_regs.sv -----
module bdpc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdpc_pkg::AddrW-1:0] paddr,
  input  logic [bdpc_pkg::DataW-1:0] pwdata,
  output logic [bdpc_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output bdpc_pkg::cfg_t             cfg_o
);
  import bdpc_pkg::*;

  logic [TimeW-1:0] long_press_q, long_press_d;
  logic [TimeW-1:0] debounce_q, debounce_d;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  // word aligned: byte offset bits are ignored
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    long_press_d = long_press_q;
    debounce_d   = debounce_q;
    if (wr_en) begin
      case (idx)
        REG_LONG_PRESS: long_press_d = pwdata[TimeW-1:0];
        REG_DEBOUNCE:   debounce_d   = pwdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LONG_PRESS: prdata = DataW'(long_press_q);
      REG_DEBOUNCE:   prdata = DataW'(debounce_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LongPressRst;
      debounce_q   <= DebounceRst;
    end else begin
      long_press_q <= long_press_d;
      debounce_q   <= debounce_d;
    end
  end

  assign cfg_o.long_press_ms = long_press_q;
  assign cfg_o.debounce_ms   = debounce_q;
endmodule

// ----- src/bdpc_eval.sv -----
module bdpc_eval (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bdpc_pkg::poll_t   poll_i,
  input  bdpc_pkg::cfg_t    cfg_i,
  output bdpc_pkg::result_t res_o
);
  import bdpc_pkg::*;

  logic             prev_raw_q, prev_raw_d;
  logic [TimeW-1:0] change_time_q, change_time_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] press_start_q, press_start_d;
  logic             short_q, short_d;
  logic             long_q, long_d;
  logic             fired_q, fired_d;

  logic             raw_chg, settle, rise, fall, fired_mid;
  logic             short_set, long_hit, short_now, long_now;
  logic [TimeW-1:0] deb_age, age_old, held;

  always_comb begin
    raw_chg       = poll_i.raw_pressed != prev_raw_q;
    prev_raw_d    = poll_i.raw_pressed;
    change_time_d = raw_chg ? poll_i.now_ms : change_time_q;
    deb_age       = raw_chg ? '0 : poll_i.now_ms - change_time_q;
    settle        = deb_age > cfg_i.debounce_ms;
    stable_d      = settle ? poll_i.raw_pressed : stable_q;
    rise          = settle & poll_i.raw_pressed & ~stable_q;
    fall          = settle & ~poll_i.raw_pressed & stable_q;

    age_old       = poll_i.now_ms - press_start_q;
    press_start_d = rise ? poll_i.now_ms : press_start_q;
    fired_mid     = rise ? 1'b0 : fired_q;
    held          = rise ? '0 : age_old;

    short_set     = fall & ~fired_q & (age_old < cfg_i.long_press_ms);
    long_hit      = stable_d & ~fired_mid & (held >= cfg_i.long_press_ms);
    fired_d       = fired_mid | long_hit;
    short_now     = short_q | short_set;
    long_now      = long_q | long_hit;
    short_d       = short_now & ~poll_i.clear_short;
    long_d        = long_now & ~poll_i.clear_long;

    res_o.pressed       = stable_d;
    res_o.short_event   = short_now;
    res_o.long_event    = long_now;
    res_o.hold_duration = stable_d ? held : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q    <= 1'b0;
      change_time_q <= '0;
      stable_q      <= 1'b0;
      press_start_q <= '0;
      short_q       <= 1'b0;
      long_q        <= 1'b0;
      fired_q       <= 1'b0;
    end else if (step_i) begin
      prev_raw_q    <= prev_raw_d;
      change_time_q <= change_time_d;
      stable_q      <= stable_d;
      press_start_q <= press_start_d;
      short_q       <= short_d;
      long_q        <= long_d;
      fired_q       <= fired_d;
    end
  end
endmodule

// ----- src/button_debounce_press_classifier_core.sv -----
// Button debouncer with short/long press classification. Each item is one poll (timestamp in
// ms, raw level, two flag clears) and yields exactly one result item. An item passes an input
// register, combinational evaluation against the debounce/press state, and a result register:
// the result register loads from the evaluation when it is empty or its item is being taken,
// so a stalled result side holds items back, and one item is accepted every cycle while the
// result side keeps up. Thresholds are written over the APB port (long press at 0x0,
// debounce at 0x4) and take effect for the next item evaluated.
module button_debounce_press_classifier_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bdpc_in_if.sink                    in_i,
  bdpc_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdpc_pkg::AddrW-1:0] paddr,
  input  logic [bdpc_pkg::DataW-1:0] pwdata,
  output logic [bdpc_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import bdpc_pkg::*;

  cfg_t    cfg;
  poll_t   poll_q, poll_d;
  result_t res, res_q;
  logic    in_vld_q, out_vld_q;
  logic    step, in_take;

  assign step    = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~in_vld_q | step;
  assign in_take = in_i.valid & in_i.ready;

  always_comb begin
    poll_d.now_ms      = in_i.now_ms;
    poll_d.raw_pressed = in_i.raw_pressed;
    poll_d.clear_short = in_i.clear_short;
    poll_d.clear_long  = in_i.clear_long;
  end

  bdpc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bdpc_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .poll_i (poll_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      poll_q <= poll_d;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.pressed       = res_q.pressed;
  assign out_o.short_event   = res_q.short_event;
  assign out_o.long_event    = res_q.long_event;
  assign out_o.hold_duration = res_q.hold_duration;
endmodule

// ----- src/bdpc_checker.sv -----
`include "button_debounce_press_classifier_core_defines.svh"

module bdpc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_pressed,
  input logic out_hold_nz,
  input logic pready
);
  logic in_acc;

  assign in_acc = in_valid & in_ready;

  `BDPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `BDPC_ASSERT_NOW(a_pready, 1'b1, pready)
  `BDPC_ASSERT_NOW(a_release_zero_hold, out_valid && !out_pressed, !out_hold_nz)
  `BDPC_ASSERT_NOW(a_result_from_item, $rose(out_valid), $past(in_acc, 2))
endmodule

bind button_debounce_press_classifier_core bdpc_checker u_bdpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_pressed (out_o.pressed),
  .out_hold_nz (|out_o.hold_duration),
  .pready      (pready)
);

// ----- tb/button_debounce_press_classifier_core_test.sv -----
`timescale 1ns / 100ps

module button_debounce_press_classifier_core_test;
  import bdpc_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  bdpc_in_if  poll_if ();
  bdpc_out_if res_if ();

  button_debounce_press_classifier_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (poll_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and thresholds
  logic [TimeW-1:0] cfg_long_press;
  logic [TimeW-1:0] cfg_debounce;
  logic             btn_prev_raw;
  logic [TimeW-1:0] btn_change_ms;
  logic             btn_level;
  logic [TimeW-1:0] btn_press_ms;
  logic             btn_short;
  logic             btn_long;
  logic             btn_long_fired;

  poll_t       pending_polls[$];
  result_t     expected_results[$];
  logic [31:0] stim_ms;

  int unsigned n_queued;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_short;
  int unsigned n_long;
  int unsigned n_settings;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned pat_age;
  logic [15:0] stall_pat;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("timeout: %0d items still expected", expected_results.size());
    $display("button_debounce_press_classifier_core verification failed");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    n_errors++;
  endtask

  function automatic void classify_poll(input poll_t p);
    result_t     r;
    logic        was_pressed;
    logic [31:0] since_change;
    logic [31:0] held;
    if (p.raw_pressed != btn_prev_raw) btn_change_ms = p.now_ms;
    btn_prev_raw = p.raw_pressed;
    since_change = p.now_ms - btn_change_ms;
    if (since_change > cfg_debounce) begin
      was_pressed = btn_level;
      btn_level = p.raw_pressed;
      if (btn_level && !was_pressed) begin
        btn_press_ms = p.now_ms;
        btn_long_fired = 1'b0;
      end else if (!btn_level && was_pressed) begin
        held = p.now_ms - btn_press_ms;
        if (!btn_long_fired && held < cfg_long_press) begin
          btn_short = 1'b1;
          n_short++;
        end
      end
    end
    held = p.now_ms - btn_press_ms;
    if (btn_level && !btn_long_fired && held >= cfg_long_press) begin
      btn_long = 1'b1;
      btn_long_fired = 1'b1;
      n_long++;
    end
    r.pressed       = btn_level;
    r.short_event   = btn_short;
    r.long_event    = btn_long;
    r.hold_duration = btn_level ? held : '0;
    expected_results.push_back(r);
    if (p.clear_short) btn_short = 1'b0;
    if (p.clear_long) btn_long = 1'b0;
  endfunction

  // driver: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_if.valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (poll_if.valid && poll_if.ready) begin
        classify_poll(pending_polls.pop_front());
      end
      if (!(poll_if.valid && !poll_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          poll_if.valid <= 1'b0;
        end else if (pending_polls.size() > 0) begin
          poll_if.valid       <= 1'b1;
          poll_if.now_ms      <= pending_polls[0].now_ms;
          poll_if.raw_pressed <= pending_polls[0].raw_pressed;
          poll_if.clear_short <= pending_polls[0].clear_short;
          poll_if.clear_long  <= pending_polls[0].clear_long;
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          poll_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results, stalls on a rotating pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_pat = '0;
      pat_age = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result, hold_duration", res_if.hold_duration, '0);
        end else begin
          result_t want;
          want = expected_results.pop_front();
          n_checked++;
          if (res_if.pressed !== want.pressed)
            note_mismatch("pressed", 32'(res_if.pressed), 32'(want.pressed));
          if (res_if.short_event !== want.short_event)
            note_mismatch("short_event", 32'(res_if.short_event), 32'(want.short_event));
          if (res_if.long_event !== want.long_event)
            note_mismatch("long_event", 32'(res_if.long_event), 32'(want.long_event));
          if (res_if.hold_duration !== want.hold_duration)
            note_mismatch("hold_duration", res_if.hold_duration, want.hold_duration);
        end
      end
      if (pat_age == 0) begin
        pat_age = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0: stall_pat = '0;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'h0001 << $urandom_range(0, 15);
        endcase
      end
      pat_age--;
      res_if.ready <= !stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LONG_PRESS) cfg_long_press = value;
    else cfg_debounce = value;
    n_settings++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_polls.size() != 0 || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void put_poll(input logic [31:0] now, input logic raw, input logic clr_s,
                                   input logic clr_l);
    poll_t p;
    p.now_ms      = now;
    p.raw_pressed = raw;
    p.clear_short = clr_s;
    p.clear_long  = clr_l;
    pending_polls.push_back(p);
    n_queued++;
  endfunction

  function automatic void add_poll(input logic raw);
    put_poll(stim_ms, raw, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endfunction

  function automatic void bounce_to(input logic level);
    repeat ($urandom_range(0, 3)) begin
      stim_ms += $urandom_range(0, 5);
      add_poll(level);
      stim_ms += $urandom_range(0, 5);
      add_poll(!level);
    end
    stim_ms += $urandom_range(1, 5);
    add_poll(level);
  endfunction

  function automatic void settle();
    if ($urandom_range(0, 3) == 0) stim_ms += cfg_debounce;
    else stim_ms += cfg_debounce + 1 + $urandom_range(0, 2);
  endfunction

  task automatic queue_presses(input int unsigned n);
    int unsigned stop_at;
    int unsigned k;
    logic [31:0] start_ms;
    logic [31:0] hold;
    logic [31:0] part;
    stop_at = n_queued + n;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0: stim_ms = $urandom;
          1: stim_ms = stim_ms - $urandom_range(1, 100);
          default: stim_ms = stim_ms + $urandom_range(0, 3);
        endcase
        add_poll(1'($urandom_range(0, 1)));
      end else begin
        bounce_to(1'b1);
        settle();
        add_poll(1'b1);
        start_ms = stim_ms;
        case ($urandom_range(0, 4))
          0: hold = $urandom_range(0, 40);
          1: hold = cfg_long_press - 1;
          2: hold = cfg_long_press;
          3: hold = cfg_long_press + $urandom_range(1, 30);
          default: hold = $urandom_range(0, cfg_long_press);
        endcase
        k = $urandom_range(1, 4);
        part = hold / k;
        for (int j = 1; j <= k; j++) begin
          stim_ms = (j == k) ? start_ms + hold : start_ms + part * j;
          add_poll(1'b1);
        end
        bounce_to(1'b0);
        settle();
        add_poll(1'b0);
        repeat ($urandom_range(0, 2)) begin
          stim_ms += $urandom_range(1, 50);
          add_poll(1'b0);
        end
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] long_ms, input logic [31:0] deb_ms,
                           input logic [31:0] start_ms, input int unsigned n);
    write_reg(REG_LONG_PRESS, long_ms);
    write_reg(REG_DEBOUNCE, deb_ms);
    stim_ms = start_ms;
    queue_presses(n);
    wait_idle();
  endtask

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    poll_if.valid       = 1'b0;
    poll_if.now_ms      = '0;
    poll_if.raw_pressed = 1'b0;
    poll_if.clear_short = 1'b0;
    poll_if.clear_long  = 1'b0;
    res_if.ready        = 1'b0;
    cfg_long_press      = LongPressRst;
    cfg_debounce        = DebounceRst;
    btn_prev_raw        = 1'b0;
    btn_change_ms       = '0;
    btn_level           = 1'b0;
    btn_press_ms        = '0;
    btn_short           = 1'b0;
    btn_long            = 1'b0;
    btn_long_fired      = 1'b0;
    n_queued = 0; n_checked = 0; n_errors = 0;
    n_short = 0; n_long = 0; n_settings = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: short press, long press, wrap and backwards time
    put_poll(32'd0, 1'b0, 1'b0, 1'b0);
    put_poll(32'd10, 1'b1, 1'b0, 1'b0);
    put_poll(32'd61, 1'b1, 1'b0, 1'b0);
    put_poll(32'd500, 1'b0, 1'b0, 1'b0);
    put_poll(32'd551, 1'b0, 1'b1, 1'b0);
    put_poll(32'd560, 1'b0, 1'b0, 1'b0);
    put_poll(32'd600, 1'b1, 1'b1, 1'b1);
    put_poll(32'd651, 1'b1, 1'b0, 1'b0);
    put_poll(32'd1651, 1'b1, 1'b0, 1'b1);
    put_poll(32'd1660, 1'b1, 1'b0, 1'b0);
    put_poll(32'd1700, 1'b0, 1'b0, 1'b0);
    put_poll(32'd1751, 1'b0, 1'b0, 1'b0);
    put_poll(32'hFFFF_FF00, 1'b1, 1'b0, 1'b0);
    put_poll(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    put_poll(32'h0000_0010, 1'b1, 1'b0, 1'b0);
    put_poll(32'h0000_0005, 1'b1, 1'b0, 1'b0);
    put_poll(32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1);
    put_poll(32'h7FFF_FFF0, 1'b0, 1'b1, 1'b1);
    wait_idle();

    // zero thresholds: long press fires on the accepting poll
    write_reg(REG_LONG_PRESS, 32'd0);
    write_reg(REG_DEBOUNCE, 32'd0);
    put_poll(32'd100, 1'b1, 1'b0, 1'b0);
    put_poll(32'd101, 1'b1, 1'b0, 1'b0);
    put_poll(32'd102, 1'b0, 1'b0, 1'b0);
    put_poll(32'd103, 1'b0, 1'b0, 1'b0);
    put_poll(32'd104, 1'b0, 1'b1, 1'b1);
    wait_idle();

    run_phase(32'd0, 32'd0, $urandom, 50);
    run_phase(32'd20, 32'd3, 32'd0, 80);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, 30);
    run_phase(32'hFFFF_FFFF, 32'd10, 32'hFFFF_F000, 40);
    run_phase(LongPressRst, DebounceRst, 32'hFFFF_FE00, 80);
    run_phase($urandom_range(1, 500), $urandom_range(0, 40), $urandom, 80);
    run_phase($urandom, $urandom >> $urandom_range(0, 31), $urandom, 40);

    $display("%0d polls over %0d register writes, %0d results checked",
             n_queued, n_settings, n_checked);
    $display("%0d short and %0d long presses predicted, %0d mismatches",
             n_short, n_long, n_errors);
    if (n_errors == 0) begin
      $display("button_debounce_press_classifier_core verification clean");
    end else begin
      $display("button_debounce_press_classifier_core verification failed");
    end
    $finish;
  end

endmodule
